>>> design/rbsm_pkg.sv
package rbsm_pkg;

   // Field widths
   localparam int COL_W    = 12;
   localparam int ROW_W    = 12;
   localparam int VAL_W    = 32;
   localparam int SUM_W    = 48;
   localparam int PROD_W   = 2 * VAL_W;
   localparam int FRAC_W   = 16;
   localparam int ROWCNT_W = 13;
   localparam int BLK_W    = 7;
   localparam int KMAX_W   = 6;
   localparam int CSR_W    = 13;

   // Register limits and reset values
   localparam logic [ROWCNT_W-1:0] ROWS_LIMIT   = 13'd4096;
   localparam logic [ROWCNT_W-1:0] ROWCNT_RESET = 13'd4096;
   localparam logic [BLK_W-1:0]    BLK_RESET    = 7'd16;

   // Saturation bounds of the Q32.16 sum
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_ENTRY = 2'd1,
      OP_FLUSH = 2'd2
   } opcode_type;

   typedef enum logic {
      CSR_ROW_COUNT  = 1'b0,
      CSR_BLOCK_SIZE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_DUMP
   } state_type;

   // Commands from the controller into the multiply-accumulate datapath
   typedef struct packed {
      logic                     load;
      logic                     entry;
      logic [COL_W-1:0]         col;
      logic [KMAX_W-1:0]        k;
      logic signed [VAL_W-1:0]  value;
      logic                     flush_rd;
      logic [KMAX_W-1:0]        flush_k;
      logic                     clear;
   } mac_ctl_type;

   // Status back from the datapath
   typedef struct packed {
      logic                     busy;
      logic signed [SUM_W-1:0]  acc_data;
   } mac_sts_type;

endpackage

>>> design/rbsm_req_if.sv
interface rbsm_req_if import rbsm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [1:0]              opcode;
   logic [COL_W-1:0]        column;
   logic [ROW_W-1:0]        row;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, output opcode, output column, output row, output value,
                   input ready);
   modport sink   (input valid, input opcode, input column, input row, input value,
                   output ready);
endinterface

>>> design/rbsm_rsp_if.sv
interface rbsm_rsp_if import rbsm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [ROW_W-1:0]        row_index;
   logic signed [SUM_W-1:0] row_sum;
   logic                    last_of_block;
   logic                    block_error;

   modport source (output valid, output row_index, output row_sum, output last_of_block,
                   output block_error, input ready);
   modport sink   (input valid, input row_index, input row_sum, input last_of_block,
                   input block_error, output ready);
endinterface

>>> design/rbsm_ram.sv
module rbsm_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port (read-first)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rbsm_mac.sv
module rbsm_mac import rbsm_pkg::*; #(
   parameter int VECTOR_DEPTH = 4096,
   parameter int MAX_BLOCK    = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  mac_ctl_type ctl,
   output mac_sts_type sts
);

   localparam int VAW = $clog2(VECTOR_DEPTH);
   localparam int KW  = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

   // Vector store
   logic [16:0]       col_wide;
   logic [VAW-1:0]    vec_addr;
   logic [VAL_W-1:0]  vec_rd_data;

   // Stage 1: x read in flight
   logic                    s1_valid_ff;
   logic [KW-1:0]           s1_k_ff;
   logic signed [VAL_W-1:0] s1_coef_ff;
   logic signed [PROD_W-1:0] product;

   // Stage 2: accumulator read in flight, product registered
   logic                    s2_valid_ff;
   logic [KW-1:0]           s2_k_ff;
   logic signed [SUM_W-1:0] s2_term_ff;

   // Accumulator store
   logic                    acc_rd_en;
   logic [KW-1:0]           acc_rd_addr;
   logic [SUM_W-1:0]        acc_rd_data;
   logic                    acc_rd_valid_ff;
   logic [MAX_BLOCK-1:0]    acc_valid_ff;
   logic [MAX_BLOCK-1:0]    acc_valid_in;
   logic signed [SUM_W-1:0] acc_stored;
   logic signed [SUM_W-1:0] acc_cur;
   logic signed [SUM_W:0]   acc_sum;
   logic signed [SUM_W-1:0] acc_sat;

   // Last write, for same-row forwarding
   logic                    fwd_valid_ff;
   logic [KW-1:0]           fwd_k_ff;
   logic signed [SUM_W-1:0] fwd_data_ff;

   assign col_wide = 17'(ctl.col);
   assign vec_addr = col_wide[VAW-1:0];

   rbsm_ram #(
      .WIDTH (VAL_W),
      .DEPTH (VECTOR_DEPTH)
   ) u_vec_ram (
      .clock   (clock),
      .wr_en   (ctl.load),
      .wr_addr (vec_addr),
      .wr_data (ctl.value),
      .rd_en   (ctl.entry),
      .rd_addr (vec_addr),
      .rd_data (vec_rd_data)
   );

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= ctl.entry;
         s2_valid_ff  <= s1_valid_ff;
         fwd_valid_ff <= s2_valid_ff & ~ctl.clear;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      s1_k_ff     <= ctl.k[KW-1:0];
      s1_coef_ff  <= ctl.value;
      s2_k_ff     <= s1_k_ff;
      s2_term_ff  <= product[PROD_W-1:FRAC_W];
      fwd_k_ff    <= s2_k_ff;
      fwd_data_ff <= acc_sat;
   end

   // Exact Q32.32 product; dropping the low bits floors it to Q32.16
   assign product = s1_coef_ff * $signed(vec_rd_data);

   // Accumulator read port is shared by the entry pipe and the flush sweep
   assign acc_rd_en   = s1_valid_ff | ctl.flush_rd;
   assign acc_rd_addr = s1_valid_ff ? s1_k_ff : ctl.flush_k[KW-1:0];

   rbsm_ram #(
      .WIDTH (SUM_W),
      .DEPTH (MAX_BLOCK)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (s2_valid_ff),
      .wr_addr (s2_k_ff),
      .wr_data (acc_sat),
      .rd_en   (acc_rd_en),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd_data)
   );

   // Entries not written since the last clear read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_rd_valid_ff <= 1'b0;
      end else if (acc_rd_en) begin
         acc_rd_valid_ff <= acc_valid_ff[acc_rd_addr];
      end
   end

   always_comb begin
      acc_valid_in = acc_valid_ff;
      if (ctl.clear) begin
         acc_valid_in = '0;
      end else if (s2_valid_ff) begin
         acc_valid_in[s2_k_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= '0;
      end else begin
         acc_valid_ff <= acc_valid_in;
      end
   end

   assign acc_stored = acc_rd_valid_ff ? $signed(acc_rd_data) : '0;

   // Read-modify-write with forwarding of the previous write
   always_comb begin
      if (fwd_valid_ff && (fwd_k_ff == s2_k_ff)) begin
         acc_cur = fwd_data_ff;
      end else begin
         acc_cur = acc_stored;
      end
      acc_sum = {acc_cur[SUM_W-1], acc_cur} + {s2_term_ff[SUM_W-1], s2_term_ff};
      if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
         acc_sat = acc_sum[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         acc_sat = acc_sum[SUM_W-1:0];
      end
   end

   assign sts.busy     = s1_valid_ff | s2_valid_ff;
   assign sts.acc_data = acc_stored;

endmodule

>>> design/row_blocked_sparse_mxv.sv
// Row-blocked sparse matrix-vector multiply in Q16.16 fixed point. Opcode 0 loads x[column]
// into the vector memory, opcode 1 multiplies a matrix entry by x[column] and adds the floored
// product into its row's saturating 48-bit accumulator, opcode 2 flushes the current block:
// one transaction per row, in row order, last row flagged, each carrying the block's error
// flag. Loads and entries are taken one per cycle; an entry runs through a pipeline
// (x read, multiply, accumulator read-modify-write) with forwarding between back-to-back
// updates of the same row. A flush first waits for that pipeline to drain, then n rows
// of the block leave at one per cycle through the accumulator memory's read port, slowed
// only by backpressure on the result channel; no transaction is taken during a flush. A
// register write restarts at block 0 and clears the accumulators and error flag; the
// vector memory keeps its contents.
module row_blocked_sparse_mxv import rbsm_pkg::*; #(
   parameter int VECTOR_DEPTH = 4096,
   parameter int MAX_BLOCK    = 64
) (
   input  logic             clock,
   input  logic             reset,
   rbsm_req_if.sink         req_ch,
   rbsm_rsp_if.source       rsp_ch,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int KW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
   localparam logic [BLK_W-1:0] MaxBlk = BLK_W'(MAX_BLOCK);

   state_type state_ff, state_in;

   logic [ROWCNT_W-1:0] row_count_ff, row_count_in;
   logic [BLK_W-1:0]    block_size_ff, block_size_in;
   logic [ROW_W-1:0]    row_beg_ff, row_beg_in;
   logic                error_ff, error_in;
   logic [KW-1:0]       k_ff, k_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]        rsp_index_ff, rsp_index_in;
   logic signed [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic                    rsp_err_ff, rsp_err_in;

   logic [ROWCNT_W-1:0] rows_eff;
   logic [BLK_W-1:0]    bs_eff;
   logic [ROWCNT_W-1:0] rows_left;
   logic [BLK_W-1:0]    row_num;
   logic [ROWCNT_W-1:0] row_off;
   logic [ROWCNT_W-1:0] next_beg;
   logic                in_block;
   logic                col_ok;
   logic                last_row;
   logic                accept;

   mac_ctl_type ctl;
   mac_sts_type sts;

   rbsm_mac #(
      .VECTOR_DEPTH (VECTOR_DEPTH),
      .MAX_BLOCK    (MAX_BLOCK)
   ) u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sts   (sts)
   );

   // Effective register values and block geometry
   always_comb begin
      if (row_count_ff == '0) begin
         rows_eff = ROWCNT_W'(1);
      end else if (row_count_ff > ROWS_LIMIT) begin
         rows_eff = ROWS_LIMIT;
      end else begin
         rows_eff = row_count_ff;
      end
      if (block_size_ff == '0) begin
         bs_eff = BLK_W'(1);
      end else if (block_size_ff > MaxBlk) begin
         bs_eff = MaxBlk;
      end else begin
         bs_eff = block_size_ff;
      end
      rows_left = rows_eff - {1'b0, row_beg_ff};
      row_num   = (rows_left > ROWCNT_W'(bs_eff)) ? bs_eff : rows_left[BLK_W-1:0];
      next_beg  = {1'b0, row_beg_ff} + ROWCNT_W'(bs_eff);
   end

   // Entry checks
   assign row_off  = {1'b0, req_ch.row} - {1'b0, row_beg_ff};
   assign in_block = (req_ch.row >= row_beg_ff) && (row_off < ROWCNT_W'(row_num));
   assign col_ok   = 17'(req_ch.column) < 17'(VECTOR_DEPTH);
   assign last_row = (BLK_W'(k_ff) + BLK_W'(1)) == row_num;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid & req_ch.ready;

   // Next state, datapath commands and output register
   always_comb begin
      state_in      = state_ff;
      row_count_in  = row_count_ff;
      block_size_in = block_size_ff;
      row_beg_in    = row_beg_ff;
      error_in      = error_ff;
      k_in          = k_ff;

      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_err_in    = rsp_err_ff;

      ctl          = '0;
      ctl.col      = req_ch.column;
      ctl.k        = row_off[KMAX_W-1:0];
      ctl.value    = req_ch.value;
      ctl.flush_k  = KMAX_W'(k_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (opcode_type'(req_ch.opcode))
                  OP_LOAD: begin
                     ctl.load = col_ok;
                  end
                  OP_ENTRY: begin
                     if (in_block && col_ok) begin
                        ctl.entry = 1'b1;
                     end else begin
                        error_in = 1'b1;
                     end
                  end
                  OP_FLUSH: begin
                     state_in = ST_DRAIN;
                  end
                  default: ;
               endcase
            end
         end
         ST_DRAIN: begin
            if (!sts.busy) begin
               ctl.flush_rd = 1'b1;
               ctl.flush_k  = '0;
               k_in         = '0;
               state_in     = ST_DUMP;
            end
         end
         ST_DUMP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = row_beg_ff + ROW_W'(k_ff);
               rsp_sum_in   = sts.acc_data;
               rsp_last_in  = last_row;
               rsp_err_in   = error_ff;
               if (last_row) begin
                  ctl.clear = 1'b1;
                  error_in  = 1'b0;
                  if (next_beg >= rows_eff) begin
                     row_beg_in = '0;
                  end else begin
                     row_beg_in = next_beg[ROW_W-1:0];
                  end
                  state_in = ST_IDLE;
               end else begin
                  k_in         = k_ff + KW'(1);
                  ctl.flush_rd = 1'b1;
                  ctl.flush_k  = KMAX_W'(k_in);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register write restarts the stream
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW_COUNT:  row_count_in  = csr_wdata[ROWCNT_W-1:0];
            CSR_BLOCK_SIZE: block_size_in = csr_wdata[BLK_W-1:0];
            default: ;
         endcase
         row_beg_in = '0;
         error_in   = 1'b0;
         ctl.clear  = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_count_ff  <= ROWCNT_RESET;
         block_size_ff <= BLK_RESET;
         row_beg_ff    <= '0;
         error_ff      <= 1'b0;
         k_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_count_ff  <= row_count_in;
         block_size_ff <= block_size_in;
         row_beg_ff    <= row_beg_in;
         error_ff      <= error_in;
         k_ff          <= k_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.row_index     = rsp_index_ff;
   assign rsp_ch.row_sum       = rsp_sum_ff;
   assign rsp_ch.last_of_block = rsp_last_ff;
   assign rsp_ch.block_error   = rsp_err_ff;

endmodule

>>> tb/sv/rbsm_result_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and register ports, predicts the row sums of
// every flushed block and compares them with the result transactions.
module rbsm_result_checker import rbsm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   rbsm_req_if              req_ch,
   rbsm_rsp_if              rsp_ch,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               mismatch_count,
   output int               rows_in_flight
);

   localparam int X_DEPTH  = 4096;
   localparam int ACC_ROWS = 64;

   typedef struct {
      logic [ROW_W-1:0]        row_index;
      logic signed [SUM_W-1:0] row_sum;
      logic                    last_of_block;
      logic                    block_error;
   } row_result_type;

   // Shadow copy of the block state
   logic signed [VAL_W-1:0] x_mem [X_DEPTH];
   logic signed [SUM_W-1:0] row_acc [ACC_ROWS];
   logic [ROW_W-1:0]        blk_idx;
   logic                    blk_err;
   logic [ROWCNT_W-1:0]     row_count_reg;
   logic [BLK_W-1:0]        block_size_reg;
   row_result_type          expected_rows [$];
   int                      fails = 0;

   assign mismatch_count = fails;

   initial begin
      for (int i = 0; i < X_DEPTH; i++) x_mem[i] = '0;
   end

   task automatic restart_stream();
      for (int i = 0; i < ACC_ROWS; i++) row_acc[i] = '0;
      blk_idx = '0;
      blk_err = 1'b0;
   endtask

   // Applies one accepted request; a flush queues the block's row sums
   task automatic accumulate_request(logic [1:0] op, logic [COL_W-1:0] col,
                                     logic [ROW_W-1:0] row, logic signed [VAL_W-1:0] val);
      int unsigned        nrows;
      int unsigned        bsz;
      int unsigned        base;
      int unsigned        cnt;
      int unsigned        k;
      logic signed [63:0] prod;
      logic signed [63:0] sum;
      row_result_type     res;
      nrows = (row_count_reg == 0) ? 1 : (row_count_reg > ROWS_LIMIT) ? ROWS_LIMIT
                                                                       : row_count_reg;
      bsz   = (block_size_reg == 0) ? 1 : (block_size_reg > ACC_ROWS) ? ACC_ROWS
                                                                       : block_size_reg;
      base  = blk_idx * bsz;
      if (base >= nrows) begin
         blk_idx = '0;
         base = 0;
      end
      cnt = nrows - base;
      if (cnt > bsz) cnt = bsz;
      case (op)
         OP_LOAD: x_mem[col] = val;
         OP_ENTRY: begin
            if (row < base || row - base >= cnt) begin
               blk_err = 1'b1;
            end else begin
               k = row - base;
               // floor of the Q32.32 product to Q32.16, then saturating add
               prod = val * x_mem[col];
               sum  = row_acc[k] + (prod >>> FRAC_W);
               if (sum > SUM_MAX) sum = SUM_MAX;
               if (sum < SUM_MIN) sum = SUM_MIN;
               row_acc[k] = sum[SUM_W-1:0];
            end
         end
         OP_FLUSH: begin
            for (k = 0; k < cnt; k++) begin
               res.row_index     = ROW_W'(base + k);
               res.row_sum       = row_acc[k];
               res.last_of_block = (k + 1 == cnt);
               res.block_error   = blk_err;
               expected_rows.push_back(res);
            end
            for (int i = 0; i < ACC_ROWS; i++) row_acc[i] = '0;
            blk_err = 1'b0;
            if (base + bsz >= nrows) blk_idx = '0;
            else blk_idx = blk_idx + 1'b1;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      row_result_type want;
      if (reset) begin
         row_count_reg  = ROWCNT_RESET;
         block_size_reg = BLK_RESET;
         restart_stream();
         expected_rows.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ROW_COUNT) row_count_reg = csr_wdata[ROWCNT_W-1:0];
            else block_size_reg = csr_wdata[BLK_W-1:0];
            restart_stream();
         end
         // compare first: a flush taken at this edge cannot answer at this edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rows.size() == 0) begin
               $error("unexpected result transaction: row_index %0d row_sum %0d",
                      rsp_ch.row_index, rsp_ch.row_sum);
               fails++;
            end else begin
               want = expected_rows.pop_front();
               if (rsp_ch.row_index !== want.row_index) begin
                  $error("row_index expected %0d actual %0d", want.row_index,
                         rsp_ch.row_index);
                  fails++;
               end
               if (rsp_ch.row_sum !== want.row_sum) begin
                  $error("row_sum expected %0d actual %0d", want.row_sum, rsp_ch.row_sum);
                  fails++;
               end
               if (rsp_ch.last_of_block !== want.last_of_block) begin
                  $error("last_of_block expected %0d actual %0d", want.last_of_block,
                         rsp_ch.last_of_block);
                  fails++;
               end
               if (rsp_ch.block_error !== want.block_error) begin
                  $error("block_error expected %0d actual %0d", want.block_error,
                         rsp_ch.block_error);
                  fails++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            accumulate_request(req_ch.opcode, req_ch.column, req_ch.row, req_ch.value);
      end
      rows_in_flight <= expected_rows.size();
   end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
   import rbsm_pkg::*;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          LONG_HOLD   = 400;
   localparam int          DRAIN_PAUSE = 8;
   localparam int          PHASES      = 9;
   localparam int          PHASE_ITEMS = 26;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;
   int               mismatch_count;
   int               rows_in_flight;

   // Stimulus shaping, shared with the result receiver
   int               gap_pct;
   int               stall_pct;
   bit               hold_request;
   bit               hold_done;

   // Block position and loaded x columns, used to build well-formed entries
   int unsigned      eff_rows;
   int unsigned      eff_bs;
   int unsigned      blk_base;
   bit               col_loaded [4096];
   logic [COL_W-1:0] loaded_cols [$];

   rbsm_req_if req_ch ();
   rbsm_rsp_if rsp_ch ();

   row_blocked_sparse_mxv uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rbsm_result_checker result_chk (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .rows_in_flight (rows_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // Result receiver: random stall bursts, one long hold on request
   initial begin
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b1;
         end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   function automatic logic [31:0] rand_value();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(3))
         0: ;
         1: v = {{12{v[19]}}, v[19:0]};
         2: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: v = {{14{v[17]}}, v[17:0]};
      endcase
      return v;
   endfunction

   // One request transaction, with an optional idle burst ahead of it
   task automatic send_req(logic [1:0] op, logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                           logic [VAL_W-1:0] val);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.column <= col;
      req_ch.row    <= row;
      req_ch.value  <= val;
      do @(posedge clock); while (!req_ch.ready);
      if (op == OP_LOAD && !col_loaded[col]) begin
         col_loaded[col] = 1'b1;
         loaded_cols.push_back(col);
      end
      if (op == OP_FLUSH)
         blk_base = (blk_base + eff_bs >= eff_rows) ? 0 : blk_base + eff_bs;
   endtask

   // Wait until every queued row sum has come back, then let the pipeline settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (rows_in_flight != 0);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // Both registers, back to back; restarts the stream at block 0
   task automatic configure(logic [CSR_W-1:0] rc, logic [CSR_W-1:0] bs);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROW_COUNT;
      csr_wdata <= rc;
      @(posedge clock);
      csr_index <= CSR_BLOCK_SIZE;
      csr_wdata <= bs;
      @(posedge clock);
      csr_we    <= 1'b0;
      eff_rows = (rc == 0) ? 1 : (rc > 4096) ? 4096 : rc;
      eff_bs   = (bs[6:0] == 0) ? 1 : (bs[6:0] > 64) ? 64 : bs[6:0];
      blk_base = 0;
   endtask

   // Mostly in-block entries over loaded columns, plus loads, flushes and noise
   task automatic send_random_item();
      int unsigned      pick;
      int unsigned      len;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      pick = $urandom_range(99);
      if (pick < 15) begin
         send_req(OP_LOAD, COL_W'($urandom_range(4095)), ROW_W'($urandom_range(4095)),
                  rand_value());
      end else if (pick < 80) begin
         len = eff_rows - blk_base;
         if (len > eff_bs) len = eff_bs;
         if ($urandom_range(4) != 0) row = ROW_W'(blk_base + $urandom_range(len - 1));
         else row = ROW_W'($urandom_range(4095));
         col = loaded_cols[$urandom_range(loaded_cols.size() - 1)];
         send_req(OP_ENTRY, col, row, rand_value());
      end else if (pick < 96) begin
         send_req(OP_FLUSH, COL_W'($urandom_range(4095)), ROW_W'($urandom_range(4095)),
                  $urandom);
      end else begin
         send_req(OP_UNUSED, COL_W'($urandom_range(4095)), ROW_W'($urandom_range(4095)),
                  $urandom);
      end
   endtask

   initial begin
      logic [CSR_W-1:0] rc;
      logic [6:0]       bs_low;
      reset         = 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.opcode <= OP_LOAD;
      req_ch.column <= '0;
      req_ch.row    <= '0;
      req_ch.value  <= '0;
      csr_we        <= 1'b0;
      csr_index     <= CSR_ROW_COUNT;
      csr_wdata     <= '0;
      gap_pct       = 30;
      stall_pct     = 30;
      hold_request  = 1'b0;
      eff_rows      = 4096;
      eff_bs        = 16;
      blk_base      = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: x extremes, saturation both ways, floor of a negative product,
      // same-row back-to-back updates, an entry outside the block, unused opcode
      send_req(OP_LOAD, 12'd0, 12'd0, 32'h8000_0000);
      send_req(OP_LOAD, 12'd4095, 12'd4095, 32'h7FFF_FFFF);
      send_req(OP_LOAD, 12'd1, 12'd0, 32'h0000_0001);
      send_req(OP_LOAD, 12'd2, 12'd0, 32'h0001_8000);
      repeat (3) send_req(OP_ENTRY, 12'd4095, 12'd0, 32'h7FFF_FFFF);
      repeat (3) send_req(OP_ENTRY, 12'd0, 12'd1, 32'h7FFF_FFFF);
      send_req(OP_ENTRY, 12'd1, 12'd2, 32'hFFFF_FFFF);
      repeat (2) send_req(OP_ENTRY, 12'd2, 12'd15, 32'h0001_8000);
      send_req(OP_ENTRY, 12'd2, 12'd4095, 32'h0001_0000);
      send_req(OP_UNUSED, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
      send_req(OP_FLUSH, 12'd0, 12'd0, 32'h0);
      send_req(OP_ENTRY, 12'd2, 12'd16, 32'h0001_0000);
      send_req(OP_FLUSH, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
      drain();
      // row count below range, block size above range: single-row blocks, wrap
      configure(13'd0, 13'd127);
      send_req(OP_ENTRY, 12'd0, 12'd0, 32'h8000_0000);
      send_req(OP_FLUSH, 12'd0, 12'd0, 32'h0);
      send_req(OP_FLUSH, 12'd0, 12'd0, 32'h0);
      drain();
      // row count above range, block size zero
      configure(13'h1FFF, 13'd0);
      send_req(OP_ENTRY, 12'd4095, 12'd0, 32'h0001_0000);
      send_req(OP_FLUSH, 12'd0, 12'd0, 32'h0);
      send_req(OP_FLUSH, 12'd0, 12'd0, 32'h0);
      drain();

      // Random phases, one register setting each
      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(4))
            0: rc = CSR_W'($urandom_range(1));
            1: rc = 13'd4096;
            2: rc = 13'h1FFF;
            3: rc = CSR_W'($urandom_range(1, 300));
            default: rc = CSR_W'($urandom_range(1, 64));
         endcase
         case ($urandom_range(3))
            0: bs_low = 7'($urandom_range(1));
            1: bs_low = $urandom_range(1) ? 7'd64 : 7'd127;
            default: bs_low = 7'($urandom_range(1, 64));
         endcase
         if (phase == 0) begin
            rc = 13'd4096;
            bs_low = 7'd64;
         end else if (phase == 1) begin
            rc = 13'd1;
            bs_low = 7'd1;
         end
         configure(rc, {6'($urandom_range(63)), bs_low});
         if (phase == PHASES - 1) begin
            gap_pct = 0;
            stall_pct = 0;
         end else begin
            gap_pct = ($urandom_range(2) == 0) ? 0 : 25;
            stall_pct = ($urandom_range(2) == 0) ? 0 : 35;
         end
         if (phase == 2) begin
            // receiver holds off while flushes keep arriving
            hold_request = 1'b1;
            send_req(OP_FLUSH, 12'd0, 12'd0, 32'h0);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 4 && n == PHASE_ITEMS / 2) drain();
            send_random_item();
         end
         send_req(OP_FLUSH, 12'd0, 12'd0, 32'h0);
         drain();
      end

      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
